[rtl/core/mfs_pkg.sv]
// Shared types, constants and codes for the metaball field shader.
`default_nettype none
package mfs_pkg;

    // Blob table and screen size.
    localparam int NUM_BLOBS   = 4;
    localparam int HALF_WIDTH  = 160;
    localparam int HALF_HEIGHT = 120;
    localparam int BLOB_IDX_W  = (NUM_BLOBS > 1) ? $clog2(NUM_BLOBS) : 1;
    localparam logic [BLOB_IDX_W-1:0] LAST_BLOB = BLOB_IDX_W'(NUM_BLOBS - 1);

    // Field widths.
    localparam int COORD_W  = 12;
    localparam int RADIUS_W = 10;
    localparam int PIXEL_W  = 8;
    localparam int GAIN_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int D2_W     = 26;
    localparam int NUMER_W  = 32;
    localparam int SUM_W    = 14;
    localparam int QUO_BITS = 14;

    // Field sum and ramp constants.
    localparam logic [SUM_W-1:0] SUM_MAX  = 14'd8192;
    localparam logic [D2_W-1:0]  D2_BIAS  = 26'd256;
    localparam logic [15:0]      KNEE_LO5 = 16'd16384;
    localparam logic [15:0]      KNEE_HI5 = 16'd32768;
    localparam logic [7:0]       LOW_TOP  = 8'd60;
    localparam logic [15:0]      MID_SPAN = 16'd195;
    localparam logic [15:0]      LOW_SCALE = 16'd300;

    // Gain register reset values.
    localparam logic [GAIN_W-1:0] RED_GAIN_RST   = 9'd256;
    localparam logic [GAIN_W-1:0] GREEN_GAIN_RST = 9'd128;
    localparam logic [GAIN_W-1:0] BLUE_GAIN_RST  = 9'd0;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAIN  = 2'd2;

    // Operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic                   op;
        logic [1:0]             blob_index;
        logic [COORD_W-1:0]     blob_x;
        logic [COORD_W-1:0]     blob_y;
        logic [RADIUS_W-1:0]    blob_radius;
        logic [PIXEL_W-1:0]     pixel_x;
        logic [PIXEL_W-1:0]     pixel_y;
    } in_t;

    typedef struct packed {
        logic [15:0] color;
        logic [7:0]  intensity;
    } out_t;

    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [RADIUS_W-1:0] radius;
    } blob_t;

    typedef struct packed {
        logic                  we;
        logic [BLOB_IDX_W-1:0] idx;
        blob_t                 blob;
    } blob_wr_t;

    typedef struct packed {
        logic               start;
        logic [NUMER_W-1:0] numer;
        logic [D2_W-1:0]    denom;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

[rtl/core/metaball_field_shader.sv]
// Metaball field shader top level: sequencer, shared multiplier, ramp and RGB565 packing.
`default_nettype none
// A load transfer (op = 0) writes one blob slot and gives no result; a
// slot at or beyond the blob count is dropped. A pixel transfer (op = 1)
// inside the half-resolution screen gives one result; one outside it is
// dropped without a result. For each blob the sequencer forms dx^2, dy^2
// and r^2 on one shared 16x16 multiplier, then the divider registers the
// request, checks for a term of 4.0 or more and, unless it saturates
// there to 2.0, produces the Q2.12 term r^2/(d2+1) one quotient bit per
// cycle in fourteen steps; the term is added into the saturating field
// sum as the divider's done flag rises. The ramp and the three colour
// gains then use the multiplier in turn (ST_RAMP, ST_COL_R, ST_COL_G,
// ST_COL_B) and the result loads the output register from ST_EMIT.
// in_stall is high while a pixel is in progress. The output register
// holds a finished result until it transfers, and the block takes new
// items meanwhile; a pixel that finishes while the previous result is
// still stalled waits for it. Write the gain registers only while no
// pixel is in progress.
module metaball_field_shader (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  mfs_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output mfs_pkg::out_t                  out_data,
    input  logic                           cfg_we,
    input  logic [mfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfs_pkg::GAIN_W-1:0]     cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_R,
        ST_DIV,
        ST_RAMP,
        ST_COL_R,
        ST_COL_G,
        ST_COL_B,
        ST_EMIT
    } state_t;

    state_t                               state_reg, state_next;
    logic [mfs_pkg::PIXEL_W-1:0]          px_reg, px_next;
    logic [mfs_pkg::PIXEL_W-1:0]          py_reg, py_next;
    logic [mfs_pkg::BLOB_IDX_W-1:0]       blob_reg, blob_next;
    logic [mfs_pkg::D2_W-1:0]             d2_reg, d2_next;
    logic [mfs_pkg::SUM_W-1:0]            sum_reg, sum_next;
    logic [7:0]                           inten_reg, inten_next;
    logic [4:0]                           red_reg, red_next;
    logic [5:0]                           grn_reg, grn_next;
    logic [4:0]                           blu_reg, blu_next;
    logic [mfs_pkg::GAIN_W-1:0]           red_gain_reg, red_gain_next;
    logic [mfs_pkg::GAIN_W-1:0]           green_gain_reg, green_gain_next;
    logic [mfs_pkg::GAIN_W-1:0]           blue_gain_reg, blue_gain_next;
    logic                                 out_valid_reg, out_valid_next;
    mfs_pkg::out_t                        out_data_reg, out_data_next;

    mfs_pkg::blob_wr_t                    blob_wr;
    mfs_pkg::blob_t                       blob_rd;
    mfs_pkg::div_req_t                    div_req;
    mfs_pkg::div_rsp_t                    div_rsp;

    logic                                 in_accept;
    logic                                 in_range;
    logic signed [12:0]                   dx;
    logic signed [12:0]                   dy;
    logic signed [15:0]                   mul_a;
    logic signed [15:0]                   mul_b;
    logic signed [31:0]                   prod;
    logic [15:0]                          s5;
    logic [mfs_pkg::SUM_W:0]              acc;
    logic [7:0]                           chan;

    mfs_blob_regs u_blob_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (blob_wr),
        .rd_idx  (blob_reg),
        .rd_blob (blob_rd)
    );

    mfs_divider u_divider (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && (state_reg == ST_IDLE);
    assign in_range  = ({1'b0, in_data.pixel_x} < 9'(mfs_pkg::HALF_WIDTH)) &&
                       ({1'b0, in_data.pixel_y} < 9'(mfs_pkg::HALF_HEIGHT));

    // Blob load goes straight into the table at the transfer.
    always_comb
    begin
        blob_wr.we = in_accept && (in_data.op == mfs_pkg::OP_LOAD) &&
                     (int'(in_data.blob_index) < mfs_pkg::NUM_BLOBS);
        blob_wr.idx         = mfs_pkg::BLOB_IDX_W'(in_data.blob_index);
        blob_wr.blob.x      = in_data.blob_x;
        blob_wr.blob.y      = in_data.blob_y;
        blob_wr.blob.radius = in_data.blob_radius;
    end

    // Distances in Q.4: pixel * 16 - centre.
    assign dx = $signed({1'b0, px_reg, 4'b0000}) - $signed({1'b0, blob_rd.x});
    assign dy = $signed({1'b0, py_reg, 4'b0000}) - $signed({1'b0, blob_rd.y});
    assign s5 = {sum_reg, 2'b00} + {2'b00, sum_reg};

    // Shared multiplier operand select.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_X:
            begin
                mul_a = {{3{dx[12]}}, dx};
                mul_b = {{3{dx[12]}}, dx};
            end
            ST_MUL_Y:
            begin
                mul_a = {{3{dy[12]}}, dy};
                mul_b = {{3{dy[12]}}, dy};
            end
            ST_MUL_R:
            begin
                mul_a = {6'b0, blob_rd.radius};
                mul_b = {6'b0, blob_rd.radius};
            end
            ST_RAMP:
            begin
                if (s5 > mfs_pkg::KNEE_LO5)
                begin
                    mul_a = s5 - mfs_pkg::KNEE_LO5;
                    mul_b = mfs_pkg::MID_SPAN;
                end
                else
                begin
                    mul_a = {2'b00, sum_reg};
                    mul_b = mfs_pkg::LOW_SCALE;
                end
            end
            ST_COL_R:
            begin
                mul_a = {8'b0, inten_reg};
                mul_b = {7'b0, red_gain_reg};
            end
            ST_COL_G:
            begin
                mul_a = {8'b0, inten_reg};
                mul_b = {7'b0, green_gain_reg};
            end
            ST_COL_B:
            begin
                mul_a = {8'b0, inten_reg};
                mul_b = {7'b0, blue_gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;
    // Channel = (intensity * gain) >> 8, clamped at 255 for gains above 1.0.
    assign chan = prod[16] ? 8'hFF : prod[15:8];
    assign acc  = {1'b0, sum_reg} + {1'b0, div_rsp.quotient};

    always_comb
    begin
        state_next      = state_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        blob_next       = blob_reg;
        d2_next         = d2_reg;
        sum_next        = sum_reg;
        inten_next      = inten_reg;
        red_next        = red_reg;
        grn_next        = grn_reg;
        blu_next        = blu_reg;
        red_gain_next   = red_gain_reg;
        green_gain_next = green_gain_reg;
        blue_gain_next  = blue_gain_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        div_req.start   = 1'b0;
        div_req.numer   = {prod[19:0], 12'b0};
        div_req.denom   = d2_reg;

        // Drop the held result once it transfers.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                mfs_pkg::REG_RED_GAIN:   red_gain_next   = cfg_data;
                mfs_pkg::REG_GREEN_GAIN: green_gain_next = cfg_data;
                mfs_pkg::REG_BLUE_GAIN:  blue_gain_next  = cfg_data;
                default:                 red_gain_next   = red_gain_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_data.op == mfs_pkg::OP_PIXEL) && in_range)
                begin
                    px_next    = in_data.pixel_x;
                    py_next    = in_data.pixel_y;
                    blob_next  = '0;
                    sum_next   = '0;
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:
            begin
                d2_next    = prod[mfs_pkg::D2_W-1:0] + mfs_pkg::D2_BIAS;
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                d2_next    = d2_reg + prod[mfs_pkg::D2_W-1:0];
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                // Launch r^2 << 12 over d2.
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    sum_next = (acc > {1'b0, mfs_pkg::SUM_MAX}) ? mfs_pkg::SUM_MAX
                                                                 : acc[mfs_pkg::SUM_W-1:0];
                    if (blob_reg == mfs_pkg::LAST_BLOB)
                    begin
                        state_next = ST_RAMP;
                    end
                    else
                    begin
                        blob_next  = blob_reg + 1'b1;
                        state_next = ST_MUL_X;
                    end
                end
            end
            ST_RAMP:
            begin
                // Three segments: flat top, steep middle, shallow low end.
                if (s5 > mfs_pkg::KNEE_HI5)
                begin
                    inten_next = 8'hFF;
                end
                else if (s5 > mfs_pkg::KNEE_LO5)
                begin
                    inten_next = mfs_pkg::LOW_TOP + prod[21:14];
                end
                else
                begin
                    inten_next = prod[21:14];
                end
                state_next = ST_COL_R;
            end
            ST_COL_R:
            begin
                red_next   = chan[7:3];
                state_next = ST_COL_G;
            end
            ST_COL_G:
            begin
                grn_next   = chan[7:2];
                state_next = ST_COL_B;
            end
            ST_COL_B:
            begin
                blu_next   = chan[7:3];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Hold here while the previous result is still stalled.
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.color     = {red_reg, grn_reg, blu_reg};
                    out_data_next.intensity = inten_reg;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            blob_reg       <= '0;
            out_valid_reg  <= 1'b0;
            red_gain_reg   <= mfs_pkg::RED_GAIN_RST;
            green_gain_reg <= mfs_pkg::GREEN_GAIN_RST;
            blue_gain_reg  <= mfs_pkg::BLUE_GAIN_RST;
        end
        else
        begin
            state_reg      <= state_next;
            blob_reg       <= blob_next;
            out_valid_reg  <= out_valid_next;
            red_gain_reg   <= red_gain_next;
            green_gain_reg <= green_gain_next;
            blue_gain_reg  <= blue_gain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        d2_reg       <= d2_next;
        sum_reg      <= sum_next;
        inten_reg    <= inten_next;
        red_reg      <= red_next;
        grn_reg      <= grn_next;
        blu_reg      <= blu_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

[rtl/core/mfs_blob_regs.sv]
// Blob table: centre and radius for each blob, one write port, one read port.
`default_nettype none
module mfs_blob_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mfs_pkg::blob_wr_t               wr,
    input  logic [mfs_pkg::BLOB_IDX_W-1:0]  rd_idx,
    output mfs_pkg::blob_t                  rd_blob
);

    mfs_pkg::blob_t blob_reg [mfs_pkg::NUM_BLOBS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mfs_pkg::NUM_BLOBS; i++)
            begin
                blob_reg[i] <= '0;
            end
        end
        else if (wr.we)
        begin
            blob_reg[wr.idx] <= wr.blob;
        end
    end

    assign rd_blob = blob_reg[rd_idx];

endmodule
`default_nettype wire

[rtl/core/mfs_divider.sv]
// Restoring divider for one field term, one quotient bit per cycle, saturating at 2.0.
`default_nettype none
module mfs_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  mfs_pkg::div_req_t req,
    output mfs_pkg::div_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          chk_reg, chk_next;
    logic                          done_reg, done_next;
    logic [3:0]                    cnt_reg, cnt_next;
    logic [mfs_pkg::D2_W-1:0]      rem_reg, rem_next;
    logic [mfs_pkg::D2_W-1:0]      den_reg, den_next;
    logic [mfs_pkg::QUO_BITS-1:0]  lo_reg, lo_next;
    logic [mfs_pkg::SUM_W-1:0]     quo_reg, quo_next;
    logic [mfs_pkg::D2_W:0]        trial;
    logic                          ge;

    assign trial = {rem_reg, lo_reg[mfs_pkg::QUO_BITS-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        chk_next  = chk_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        lo_next   = lo_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            // Upper numerator bits seed the remainder; the rest shift in.
            rem_next  = mfs_pkg::D2_W'(req.numer[mfs_pkg::NUMER_W-1:mfs_pkg::QUO_BITS]);
            lo_next   = req.numer[mfs_pkg::QUO_BITS-1:0];
            den_next  = req.denom;
            quo_next  = '0;
            busy_next = 1'b1;
            chk_next  = 1'b1;
        end
        else if (busy_reg && chk_reg)
        begin
            // Quotient of 16384 or more: saturate at once.
            if (rem_reg >= den_reg)
            begin
                quo_next  = mfs_pkg::SUM_MAX;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            chk_next = 1'b0;
            cnt_next = 4'(mfs_pkg::QUO_BITS - 1);
        end
        else if (busy_reg)
        begin
            rem_next = ge ? mfs_pkg::D2_W'(trial - {1'b0, den_reg})
                          : trial[mfs_pkg::D2_W-1:0];
            quo_next = {quo_reg[mfs_pkg::SUM_W-2:0], ge};
            lo_next  = {lo_reg[mfs_pkg::QUO_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            chk_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            chk_reg  <= chk_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = (quo_reg > mfs_pkg::SUM_MAX) ? mfs_pkg::SUM_MAX : quo_reg;

endmodule
`default_nettype wire
